[sv/ims_pkg.sv]
// Shared types, widths and segment tables for the IEC meter scale block.
package ims_pkg;

    // Sample and result widths.
    localparam int SAMPLE_BITS = 16;
    localparam int AMP_W       = SAMPLE_BITS;
    localparam int SCALE_W     = 10;
    localparam int SCALE_MAX   = 1000;

    // The log2 datapath: leading-one index, Q30 mantissa and 16 fraction bits.
    localparam int MSB_W   = $clog2(AMP_W);
    localparam int FRAC_W  = 16;
    localparam int MANT_Q  = 30;
    localparam int MANT_W  = MANT_Q + 1;
    localparam int SHIFT_W = $clog2(MANT_Q + 1);

    // The signed log2 of the ratio keeps two spare bits over its magnitude.
    localparam int LG_W = MSB_W + FRAC_W + 2;

    // 20*log10(2) in Q16, rounded to nearest, as a signed multiplier operand.
    localparam int DB_PER_OCTAVE_Q16 = 394566;
    localparam int DBK_W             = 20;
    localparam int DB_Q              = 32;
    localparam int DB_W              = LG_W + DBK_W;

    // Segment selection and the linear map.
    localparam int NUM_SEGS  = 6;
    localparam int SEG_W     = $clog2(NUM_SEGS);
    // The widest segment spans 20 dB, so the offset into it stays below 20*2^32.
    localparam int X_W       = 37;
    localparam int SLOPE_W   = 6;
    localparam int OFF_W     = 10;
    localparam int PROD_W    = X_W + SLOPE_W;
    localparam int SUM_W     = PROD_W + 1;

    typedef logic [AMP_W-1:0]   t_amp;
    typedef logic [SCALE_W-1:0] t_scale;
    typedef logic [SEG_W-1:0]   t_seg;

    // Lower breakpoint of a segment in dB, placed in Q32.
    function automatic logic signed [DB_W-1:0] seg_bp_q(input t_seg idx);
        logic signed [7:0] bp;
        unique case (idx)
            3'd0:    bp = -8'sd70;
            3'd1:    bp = -8'sd60;
            3'd2:    bp = -8'sd50;
            3'd3:    bp = -8'sd40;
            3'd4:    bp = -8'sd30;
            3'd5:    bp = -8'sd20;
            default: bp = -8'sd20;
        endcase
        return DB_W'(bp) <<< DB_Q;
    endfunction

    // Slope of a segment in half-thousandths per dB.
    function automatic logic [SLOPE_W-1:0] seg_slope2(input t_seg idx);
        logic [SLOPE_W-1:0] s;
        unique case (idx)
            3'd0:    s = 6'd5;
            3'd1:    s = 6'd10;
            3'd2:    s = 6'd15;
            3'd3:    s = 6'd30;
            3'd4:    s = 6'd40;
            3'd5:    s = 6'd50;
            default: s = 6'd50;
        endcase
        return s;
    endfunction

    // Deflection at the lower breakpoint of a segment, in thousandths.
    function automatic logic [OFF_W-1:0] seg_off(input t_seg idx);
        logic [OFF_W-1:0] o;
        unique case (idx)
            3'd0:    o = 10'd0;
            3'd1:    o = 10'd25;
            3'd2:    o = 10'd75;
            3'd3:    o = 10'd150;
            3'd4:    o = 10'd300;
            3'd5:    o = 10'd500;
            default: o = 10'd500;
        endcase
        return o;
    endfunction

endpackage

[sv/ims_if.sv]
// Stream interfaces for amplitude samples and meter deflection results.
interface ims_amp_if;
    import ims_pkg::*;

    logic valid;
    logic ready;
    t_amp amplitude;

    modport source (output valid, output amplitude, input ready);
    modport sink   (input valid, input amplitude, output ready);
endinterface

interface ims_scale_if;
    import ims_pkg::*;

    logic   valid;
    logic   ready;
    t_scale meter_scale;

    modport source (output valid, output meter_scale, input ready);
    modport sink   (input valid, input meter_scale, output ready);
endinterface

[sv/iec_meter_scale.sv]
// Top level of the IEC 60268-18 peak meter scale pipeline.
//
// Usage:
//   i_amp carries one unsigned peak amplitude per transfer, where 2^16 is full
//   scale. o_scale carries the matching meter deflection in thousandths, 0 to
//   1000, with 1000 at 0 dBFS. Zero and anything below -70 dB give 0.
//   Every transfer in yields exactly one transfer out, in order.
//   Throughput: one transfer per cycle while the receiver does not stall.
//   The log2 unit spends one pipeline stage with one 31x31 squarer on each of
//   the 16 fraction bits; further stages do normalization, the dB multiply,
//   segment selection, the slope multiply and the rounding output register.
//   Reset clears every stage valid bit; the pipeline is then empty and ready.
//   When the receiver holds o_scale.ready low with a result waiting, the whole
//   pipeline holds and i_amp.ready goes low in the same cycle; bubbles in the
//   pipeline are not squeezed out during a stall.
module iec_meter_scale (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ims_amp_if.sink      i_amp,
    ims_scale_if.source  o_scale
);
    import ims_pkg::*;

    // Stage map: normalize, one stage per fraction bit, dB, segment, slope, output.
    localparam int ST_DB    = FRAC_W + 1;
    localparam int ST_SEG   = FRAC_W + 2;
    localparam int ST_MUL   = FRAC_W + 3;
    localparam int ST_OUT   = FRAC_W + 4;
    localparam int NUM_ST   = FRAC_W + 5;

    localparam logic signed [LG_W-1:0]  LG_BIAS = LG_W'(SAMPLE_BITS * (2 ** FRAC_W));
    localparam logic signed [DBK_W-1:0] DBK     = DBK_W'(DB_PER_OCTAVE_Q16);

    logic                adv;
    logic [NUM_ST-1:0]   r_vld;

    logic [MSB_W-1:0]    r_msb  [0:FRAC_W];
    logic [MANT_W-1:0]   r_y    [0:FRAC_W];
    logic [FRAC_W-1:0]   r_frac [0:FRAC_W];

    logic [MSB_W-1:0]    n_msb;
    logic [MANT_W-1:0]   n_y0;

    logic signed [LG_W-1:0] n_lg;
    logic signed [DB_W-1:0] n_db;
    logic signed [DB_W-1:0] r_db;

    t_seg                   n_seg;
    logic                   n_below;
    logic signed [DB_W-1:0] n_x_full;
    t_seg                   r_seg;
    logic                   r_below;
    logic [X_W-1:0]         r_x;

    logic [PROD_W-1:0]      n_prod;
    logic [PROD_W-1:0]      r_prod;
    t_seg                   r_seg_m;
    logic                   r_below_m;

    logic [SUM_W-1:0]       n_sum;
    logic [SUM_W-DB_Q-2:0]  n_res;
    t_scale                 n_scale;
    t_scale                 r_scale;

    // The pipeline moves whenever the output register is free or being taken.
    assign adv = !r_vld[ST_OUT] || o_scale.ready;
    assign i_amp.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NUM_ST-2:0], i_amp.valid};
        end
    end

    // Leading-one search and normalization of the mantissa to Q30 in [1,2).
    // A zero amplitude leaves a zero mantissa and ends far below -70 dB.
    always_comb begin
        n_msb = '0;
        for (int i = 1; i < AMP_W; i++) begin
            if (i_amp.amplitude[i]) n_msb = MSB_W'(i);
        end
        n_y0 = MANT_W'(i_amp.amplitude) << (SHIFT_W'(MANT_Q) - SHIFT_W'(n_msb));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_msb[0]  <= n_msb;
            r_y[0]    <= n_y0;
            r_frac[0] <= '0;
        end
    end

    // One fraction bit per stage: square the mantissa and renormalize it.
    for (genvar k = 1; k <= FRAC_W; k++) begin : g_sq
        logic [2*MANT_W-1:0] n_sq;
        logic [MANT_W:0]     n_top;

        assign n_sq  = r_y[k-1] * r_y[k-1];
        assign n_top = n_sq[MANT_Q+MANT_W:MANT_Q];

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_msb[k]  <= r_msb[k-1];
                r_frac[k] <= {r_frac[k-1][FRAC_W-2:0], n_top[MANT_W]};
                r_y[k]    <= n_top[MANT_W] ? n_top[MANT_W:1] : n_top[MANT_W-1:0];
            end
        end
    end

    // Level in dB, Q32: log2 of the ratio to full scale times 20*log10(2).
    always_comb begin
        n_lg = $signed({2'b00, r_msb[FRAC_W], r_frac[FRAC_W]}) - LG_BIAS;
        n_db = n_lg * DBK;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_db <= n_db;
        end
    end

    // Segment choice: the highest breakpoint at or below the level wins.
    always_comb begin
        n_seg = '0;
        for (int k = 1; k < NUM_SEGS; k++) begin
            if (r_db >= seg_bp_q(SEG_W'(k))) n_seg = SEG_W'(k);
        end
        n_below  = r_db < seg_bp_q('0);
        n_x_full = r_db - seg_bp_q(n_seg);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_seg   <= n_seg;
            r_below <= n_below;
            r_x     <= n_x_full[X_W-1:0];
        end
    end

    // Slope times the offset into the segment, in Q32 half-thousandths.
    assign n_prod = PROD_W'(seg_slope2(r_seg)) * PROD_W'(r_x);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod    <= n_prod;
            r_seg_m   <= r_seg;
            r_below_m <= r_below;
        end
    end

    // Add twice the segment start plus one half for rounding, then clamp; below -70 dB gives 0.
    always_comb begin
        n_sum = SUM_W'(r_prod)
              + (SUM_W'({seg_off(r_seg_m), 1'b1}) << DB_Q);
        n_res = n_sum[SUM_W-1:DB_Q+1];
        priority if (r_below_m) begin
            n_scale = '0;
        end else if (n_res > (SUM_W-DB_Q-1)'(SCALE_MAX)) begin
            n_scale = SCALE_W'(SCALE_MAX);
        end else begin
            n_scale = n_res[SCALE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_scale <= n_scale;
        end
    end

    assign o_scale.valid       = r_vld[ST_OUT];
    assign o_scale.meter_scale = r_scale;

endmodule

[sv/ims_check.sv]
// Port-level checker for the meter scale block, with its bind statement.
module ims_check (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input ims_pkg::t_scale i_out_scale
);
    import ims_pkg::*;

    // A waiting result stays offered until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transfer");

    // A waiting result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_scale))
        else $error("result changed while stalled");

    // A stall at the output reaches the input in the same cycle.
    a_stall_back: assert property (@(posedge i_clk)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while the pipeline is stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind iec_meter_scale ims_check u_ims_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_amp.ready),
    .i_out_valid (o_scale.valid),
    .i_out_ready (o_scale.ready),
    .i_out_scale (o_scale.meter_scale)
);

[tb/tb_iec_meter_scale.sv]
// Self-checking testbench for the IEC meter scale pipeline with random flow control.
`timescale 1ns / 1ps

module tb_iec_meter_scale;
    import ims_pkg::*;

    localparam int  IDLE_LIMIT  = 5000;
    localparam int  DRAIN_WAIT  = 40;
    localparam int  NUM_BANDS   = 6;
    localparam longint Q32_ONE  = 64'sd1 <<< 32;

    // Expected deflection together with the amplitude that caused it.
    typedef struct packed {
        t_amp   amplitude;
        t_scale deflection;
    } t_pending;

    logic clk;
    logic rst_n;

    ims_amp_if   amp_bus ();
    ims_scale_if scale_bus ();

    t_pending pending_q[$];
    int       fail_count  = 0;
    int       idle_cycles = 0;
    int       stall_left  = 0;
    bit       rx_stalls   = 1'b0;

    // Lower edge of each meter band in dB, slope in half-thousandths per dB,
    // and deflection at the lower edge in thousandths.
    longint band_floor_db [NUM_BANDS] = '{-70, -60, -50, -40, -30, -20};
    longint band_slope2   [NUM_BANDS] = '{5, 10, 15, 30, 40, 50};
    longint band_base     [NUM_BANDS] = '{0, 25, 75, 150, 300, 500};

    iec_meter_scale i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_amp   (amp_bus.sink),
        .o_scale (scale_bus.source)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Log2 of a nonzero amplitude in Q16, one fraction bit per squaring step.
    function automatic longint amp_log2_q16(input t_amp a);
        int                msb;
        int                i;
        longint unsigned   mant;
        longint            frac;
        msb = 0;
        for (i = 0; i < AMP_W; i++) begin
            if (a[i]) begin
                msb = i;
            end
        end
        mant = 64'(a) << (30 - msb);
        frac = 0;
        for (i = 0; i < 16; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31)) begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        return longint'(msb) * 65536 + frac;
    endfunction

    // Meter deflection in thousandths for one amplitude.
    function automatic t_scale predict_deflection(input t_amp a);
        longint          lg;
        longint          db_q32;
        longint          x;
        longint          r;
        longint unsigned res;
        int              band;
        if (a == '0) begin
            return '0;
        end
        lg     = amp_log2_q16(a) - longint'(SAMPLE_BITS) * 65536;
        db_q32 = lg * longint'(DB_PER_OCTAVE_Q16);
        if (db_q32 < band_floor_db[0] * Q32_ONE) begin
            return '0;
        end
        // A level exactly on an edge belongs to the band above it.
        band = NUM_BANDS - 1;
        while (band > 0 && db_q32 < band_floor_db[band] * Q32_ONE) begin
            band--;
        end
        x   = db_q32 - band_floor_db[band] * Q32_ONE;
        r   = band_slope2[band] * x + 2 * band_base[band] * Q32_ONE;
        res = (longint'(r) + Q32_ONE) >>> 33;
        if (res > SCALE_MAX) begin
            res = SCALE_MAX;
        end
        return t_scale'(res);
    endfunction

    // Amplitudes spread over all octaves, with some uniform and extreme values.
    function automatic t_amp random_amplitude();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return t_amp'($urandom_range(0, 65535) >> $urandom_range(0, 15));
        end else if (pick < 90) begin
            return t_amp'($urandom_range(0, 65535));
        end else if (pick < 95) begin
            return t_amp'($urandom_range(0, 31));
        end else begin
            return t_amp'($urandom_range(65500, 65535));
        end
    endfunction

    // Sender gap: mostly none or short, a few long.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            return 0;
        end else if (pick < 85) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 10);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    // Receiver ready: either always high or random stalls of mixed length.
    always @(posedge clk) begin
        if (!rx_stalls) begin
            scale_bus.ready <= 1'b1;
            stall_left      <= 0;
        end else if (stall_left > 0) begin
            scale_bus.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                scale_bus.ready <= 1'b1;
            end else if (pick < 95) begin
                scale_bus.ready <= 1'b0;
                stall_left      <= $urandom_range(0, 2);
            end else begin
                scale_bus.ready <= 1'b0;
                stall_left      <= $urandom_range(10, 40);
            end
        end
    end

    // Record each input transfer, check each output transfer, and watch for a hang.
    always @(posedge clk) begin
        if (rst_n) begin
            bit       in_xfer;
            bit       out_xfer;
            t_pending head;
            in_xfer  = amp_bus.valid && amp_bus.ready;
            out_xfer = scale_bus.valid && scale_bus.ready;
            if (out_xfer) begin
                if (pending_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, scale_bus.meter_scale);
                    fail_count++;
                end else begin
                    head = pending_q.pop_front();
                    if (scale_bus.meter_scale !== head.deflection) begin
                        $display("%0t: amplitude %0d, expected %0d, actual %0d",
                                 $time, head.amplitude, head.deflection,
                                 scale_bus.meter_scale);
                        fail_count++;
                    end
                end
            end
            if (in_xfer) begin
                pending_q.push_back('{amplitude:  amp_bus.amplitude,
                                      deflection: predict_deflection(amp_bus.amplitude)});
            end
            if (in_xfer || out_xfer) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // Send one amplitude after a gap; returns at the edge of its transfer.
    task automatic send_amplitude(input t_amp a, input int gap);
        if (gap > 0) begin
            amp_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        amp_bus.valid     <= 1'b1;
        amp_bus.amplitude <= a;
        do begin
            @(posedge clk);
        end while (!amp_bus.ready);
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic wait_for_drain();
        amp_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Zero, full scale, both sides of every band edge and alternating bit patterns.
    task automatic test_directed_levels();
        t_amp levels[$];
        levels = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd20, 16'd21, 16'd65, 16'd66,
                   16'd207, 16'd208, 16'd655, 16'd656, 16'd2072, 16'd2073,
                   16'd6553, 16'd6554, 16'd32768, 16'd65534, 16'd65535,
                   16'h5555, 16'hAAAA};
        rx_stalls = 1'b0;
        foreach (levels[i]) begin
            send_amplitude(levels[i], 0);
        end
    endtask

    // Full-rate stream with the receiver always ready.
    task automatic test_back_to_back();
        rx_stalls = 1'b0;
        repeat (150) send_amplitude(random_amplitude(), 0);
    endtask

    // Random gaps on the sender and random stalls on the receiver.
    task automatic test_random_flow();
        rx_stalls = 1'b1;
        repeat (800) send_amplitude(random_amplitude(), random_gap());
    endtask

    // Bursts that each start from an empty pipeline.
    task automatic test_drain_pause();
        rx_stalls = 1'b1;
        repeat (4) begin
            wait_for_drain();
            repeat (50) send_amplitude(random_amplitude(), random_gap());
        end
    endtask

    // Reset, run each test, then drain and report.
    initial begin
        rst_n             = 1'b0;
        amp_bus.valid     = 1'b0;
        amp_bus.amplitude = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_levels();
        test_back_to_back();
        test_random_flow();
        test_drain_pause();

        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
